// ===== hdl/srfc_pkg.sv =====
// ----------------------------------------------------------------------------
// srfc_pkg
// Shared constants, types and the bytewise Modbus CRC-16 update.
// ----------------------------------------------------------------------------
package srfc_pkg;

    localparam int FRAME_BYTES = 9;
    localparam int POS_W       = 4;
    localparam int BEAT_W      = 3;

    localparam logic [15:0] CRC_START = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    localparam logic [7:0] CHAN_AFTER_PRESSURE    = 8'h04;
    localparam logic [7:0] CHAN_AFTER_TEMPERATURE = 8'h01;

    localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd250;
    localparam logic [7:0] READ_FUNCTION_RESET  = 8'd73;

    localparam logic [POS_W-1:0] POS_CRC_HIGH = POS_W'(FRAME_BYTES - 2);

    // request frame beats
    localparam logic [BEAT_W-1:0] BEAT_REPORT  = 3'd0;
    localparam logic [BEAT_W-1:0] BEAT_ADDRESS = 3'd1;
    localparam logic [BEAT_W-1:0] BEAT_FUNC    = 3'd2;
    localparam logic [BEAT_W-1:0] BEAT_CHANNEL = 3'd3;
    localparam logic [BEAT_W-1:0] BEAT_CRC_HI  = 3'd4;
    localparam logic [BEAT_W-1:0] BEAT_CRC_LO  = 3'd5;

    // configuration register indexes
    localparam logic REG_DEVICE_ADDRESS     = 1'b0;
    localparam logic REG_READ_FUNCTION_CODE = 1'b1;

    typedef struct packed {
        logic        load;
        logic        crc_ok;
        logic        quantity;
        logic [31:0] pressure;
        logic [31:0] temperature;
    } frame_done_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== hdl/srfc_frame.sv =====
// ----------------------------------------------------------------------------
// srfc_frame
// Input register and frame tracker: running CRC, payload capture, stores.
// ----------------------------------------------------------------------------
module srfc_frame
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rx_valid,
    output logic                 rx_stall,
    input  logic [7:0]           rx_byte,
    input  logic                 emit_ready,
    output srfc_pkg::frame_done_t done
);
    import srfc_pkg::*;

    logic [7:0]       byte_reg;
    logic             byte_vld_reg, byte_vld_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    logic [31:0]      shift_reg, shift_next;
    logic             hi_match_reg, hi_match_next;
    logic             mode_reg, mode_next;
    logic [31:0]      press_reg, press_next;
    logic [31:0]      temp_reg, temp_next;

    logic is_final;
    logic advance;
    logic ok;

    assign is_final = (pos_reg > POS_CRC_HIGH);
    assign advance  = byte_vld_reg && (!is_final || emit_ready);
    assign rx_stall = byte_vld_reg && !advance;
    assign ok       = hi_match_reg && (byte_reg == crc_reg[7:0]);

    always_comb
    begin
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        shift_next    = shift_reg;
        hi_match_next = hi_match_reg;
        mode_next     = mode_reg;
        press_next    = press_reg;
        temp_next     = temp_reg;
        byte_vld_next = byte_vld_reg;

        if (rx_valid && !rx_stall)
            byte_vld_next = 1'b1;
        else if (advance)
            byte_vld_next = 1'b0;

        if (advance)
        begin
            if (pos_reg < POS_CRC_HIGH)
            begin
                crc_next = crc_byte(crc_reg, byte_reg);
                if (pos_reg >= POS_W'(2) && pos_reg <= POS_W'(5))
                    shift_next = {shift_reg[23:0], byte_reg};
                pos_next = pos_reg + POS_W'(1);
            end
            else if (pos_reg == POS_CRC_HIGH)
            begin
                hi_match_next = (byte_reg == crc_reg[15:8]);
                pos_next      = pos_reg + POS_W'(1);
            end
            else
            begin
                if (ok && !mode_reg)
                    press_next = shift_reg;
                if (ok && mode_reg)
                    temp_next = shift_reg;
                mode_next     = !mode_reg;
                pos_next      = '0;
                crc_next      = CRC_START;
                shift_next    = '0;
                hi_match_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        done.load        = advance && is_final;
        done.crc_ok      = ok;
        done.quantity    = mode_reg;
        done.pressure    = press_next;
        done.temperature = temp_next;
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && !rx_stall)
            byte_reg <= rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_vld_reg <= 1'b0;
            pos_reg      <= '0;
            crc_reg      <= CRC_START;
            shift_reg    <= '0;
            hi_match_reg <= 1'b0;
            mode_reg     <= 1'b0;
            press_reg    <= '0;
            temp_reg     <= '0;
        end
        else
        begin
            byte_vld_reg <= byte_vld_next;
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            shift_reg    <= shift_next;
            hi_match_reg <= hi_match_next;
            mode_reg     <= mode_next;
            press_reg    <= press_next;
            temp_reg     <= temp_next;
        end
    end

endmodule

// ===== hdl/srfc_emit.sv =====
// ----------------------------------------------------------------------------
// srfc_emit
// Result sequencer: one report beat, then the five request frame beats.
// ----------------------------------------------------------------------------
module srfc_emit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  srfc_pkg::frame_done_t done,
    input  logic [7:0]            device_address,
    input  logic [7:0]            read_function_code,
    output logic                  emit_ready,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  kind,
    output logic                  crc_ok,
    output logic                  quantity,
    output logic [31:0]           pressure_bits,
    output logic [31:0]           temperature_bits,
    output logic [7:0]            tx_byte,
    output logic                  last
);
    import srfc_pkg::*;

    logic [BEAT_W-1:0] beat_reg, beat_next;
    logic              busy_reg, busy_next;
    logic [15:0]       crc_reg, crc_next;
    logic              ok_reg;
    logic              qty_reg;
    logic [31:0]       press_reg;
    logic [31:0]       temp_reg;
    logic [7:0]        addr_reg;
    logic [7:0]        func_reg;
    logic              take;
    logic              is_report;
    logic [7:0]        chan;

    assign take       = busy_reg && !out_stall;
    assign emit_ready = !busy_reg || (take && beat_reg == BEAT_CRC_LO);
    assign out_valid  = busy_reg;
    assign is_report  = (beat_reg == BEAT_REPORT);
    assign chan       = qty_reg ? CHAN_AFTER_TEMPERATURE : CHAN_AFTER_PRESSURE;

    always_comb
    begin
        case (beat_reg)
            BEAT_ADDRESS: tx_byte = addr_reg;
            BEAT_FUNC:    tx_byte = func_reg;
            BEAT_CHANNEL: tx_byte = chan;
            BEAT_CRC_HI:  tx_byte = crc_reg[15:8];
            BEAT_CRC_LO:  tx_byte = crc_reg[7:0];
            default:      tx_byte = 8'h00;
        endcase
    end

    assign kind             = !is_report;
    assign crc_ok           = is_report && ok_reg;
    assign quantity         = is_report && qty_reg;
    assign pressure_bits    = is_report ? press_reg : 32'h0;
    assign temperature_bits = is_report ? temp_reg : 32'h0;
    assign last             = (beat_reg == BEAT_CRC_LO);

    always_comb
    begin
        beat_next = beat_reg;
        busy_next = busy_reg;
        crc_next  = crc_reg;
        if (done.load)
        begin
            beat_next = BEAT_REPORT;
            busy_next = 1'b1;
            crc_next  = CRC_START;
        end
        else if (take)
        begin
            if (beat_reg == BEAT_CRC_LO)
                busy_next = 1'b0;
            else
                beat_next = beat_reg + BEAT_W'(1);
            if (beat_reg == BEAT_ADDRESS || beat_reg == BEAT_FUNC ||
                beat_reg == BEAT_CHANNEL)
                crc_next = crc_byte(crc_reg, tx_byte);
        end
    end

    always_ff @(posedge clk)
    begin
        if (done.load)
        begin
            ok_reg    <= done.crc_ok;
            qty_reg   <= done.quantity;
            press_reg <= done.pressure;
            temp_reg  <= done.temperature;
            addr_reg  <= device_address;
            func_reg  <= read_function_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= BEAT_REPORT;
            busy_reg <= 1'b0;
            crc_reg  <= CRC_START;
        end
        else
        begin
            beat_reg <= beat_next;
            busy_reg <= busy_next;
            crc_reg  <= crc_next;
        end
    end

endmodule

// ===== hdl/sensor_reply_frame_checker.sv =====
// ----------------------------------------------------------------------------
// sensor_reply_frame_checker
// Checks 9-byte sensor reply frames and emits reports and request frames.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle. Each byte passes an input register
// and a registered CRC-16 update in the frame tracker. The ninth byte of a
// frame hands off to the result sequencer, which sends six beats (report,
// then five request bytes) at one beat per cycle unless out_stall is high;
// bytes of the next frame keep flowing meanwhile, and only its ninth byte
// waits until the previous six beats are all taken. Config writes never wait.
module sensor_reply_frame_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic        crc_ok,
    output logic        quantity,
    output logic [31:0] pressure_bits,
    output logic [31:0] temperature_bits,
    output logic [7:0]  tx_byte,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import srfc_pkg::*;

    logic [7:0]  dev_addr_reg;
    logic [7:0]  func_code_reg;
    logic        emit_ready;
    frame_done_t done;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg  <= DEVICE_ADDRESS_RESET;
            func_code_reg <= READ_FUNCTION_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DEVICE_ADDRESS:     dev_addr_reg  <= cfg_data;
                REG_READ_FUNCTION_CODE: func_code_reg <= cfg_data;
                default:                dev_addr_reg  <= dev_addr_reg;
            endcase
        end
    end

    srfc_frame u_frame
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .rx_byte    (rx_byte),
        .emit_ready (emit_ready),
        .done       (done)
    );

    srfc_emit u_emit
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .done               (done),
        .device_address     (dev_addr_reg),
        .read_function_code (func_code_reg),
        .emit_ready         (emit_ready),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .kind               (kind),
        .crc_ok             (crc_ok),
        .quantity           (quantity),
        .pressure_bits      (pressure_bits),
        .temperature_bits   (temperature_bits),
        .tx_byte            (tx_byte),
        .last               (last)
    );

endmodule
